// ----- rtl/rgb_upscale_three_halves_assert.svh -----
// Assertion macros shared by the scaler RTL.
`ifndef RGB_UPSCALE_THREE_HALVES_ASSERT_SVH
`define RGB_UPSCALE_THREE_HALVES_ASSERT_SVH

// Check on every clock edge outside reset.
`define RUS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RUS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/rus_pkg.sv -----
// Shared types, constants and channel-average functions of the 1.5x scaler.
`timescale 1ns / 1ps
package rus_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int FRAME_SIZE_RST = 512;

  localparam int FRAME_W_REG_W = 12;
  localparam int FRAME_H_REG_W = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 1;

  localparam int OUT_ROW_W = 13;
  localparam int OUT_COL_W = 12;
  localparam int CHAN_W    = 8;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 56;
  localparam int M_PAD_W   = M_TDATA_W - OUT_ROW_W - OUT_COL_W - 3 * CHAN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One source pixel on its way to the result sequencer.
  typedef struct packed {
    logic                 row_odd;
    logic                 col_odd;
    logic [OUT_ROW_W-1:0] base_row;
    logic [OUT_COL_W-1:0] base_col;
    pixel_t               px;
  } item_t;

  // Truncated mean of two pixels per channel (same as a,a,b,b over four).
  function automatic pixel_t avg2(pixel_t a, pixel_t b);
    logic [CHAN_W:0] sr;
    logic [CHAN_W:0] sg;
    logic [CHAN_W:0] sb;
    pixel_t          res;
    sr = {1'b0, a.red}   + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue}  + {1'b0, b.blue};
    res.red   = sr[CHAN_W:1];
    res.green = sg[CHAN_W:1];
    res.blue  = sb[CHAN_W:1];
    return res;
  endfunction

  // Truncated mean of four pixels per channel.
  function automatic pixel_t avg4(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
    logic [CHAN_W+1:0] sr;
    logic [CHAN_W+1:0] sg;
    logic [CHAN_W+1:0] sb;
    pixel_t            res;
    sr = {2'b0, a.red} + {2'b0, b.red} + {2'b0, c.red} + {2'b0, d.red};
    sg = {2'b0, a.green} + {2'b0, b.green} + {2'b0, c.green} + {2'b0, d.green};
    sb = {2'b0, a.blue} + {2'b0, b.blue} + {2'b0, c.blue} + {2'b0, d.blue};
    res.red   = sr[CHAN_W+1:2];
    res.green = sg[CHAN_W+1:2];
    res.blue  = sb[CHAN_W+1:2];
    return res;
  endfunction

endpackage

// ----- rtl/rus_line_store.sv -----
// Line store: one source row of pixels, one write and one registered read port.
`timescale 1ns / 1ps
module rus_line_store #(
  parameter int DEPTH = rus_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  rus_pkg::pixel_t               wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output rus_pkg::pixel_t               rdata_o
);

  rus_pkg::pixel_t mem_q [DEPTH];
  rus_pkg::pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rus_emit.sv -----
// Result sequencer: holds one source pixel and sends its one to four results.
`timescale 1ns / 1ps
`include "rgb_upscale_three_halves_assert.svh"
module rus_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  rus_pkg::item_t                  item_i,
  input  rus_pkg::pixel_t                 left_i,
  input  rus_pkg::pixel_t                 up_i,
  input  rus_pkg::pixel_t                 ul_i,
  output logic                            ready_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rus_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);

  typedef enum logic [1:0] {
    SRC_PX,
    SRC_MLL,
    SRC_MUP,
    SRC_M4
  } src_e;

  logic                             s1_v_q;
  logic [1:0]                       idx_q;
  rus_pkg::item_t                   item_q;
  logic                             out_v_q;
  logic [rus_pkg::M_TDATA_W-1:0]    out_data_q;
  logic                             out_last_q;

  logic [1:0]                       n_last;
  logic                             last_now;
  logic                             out_adv;
  logic                             fire;
  logic [1:0]                       row_off;
  logic [1:0]                       col_off;
  src_e                             src;
  rus_pkg::pixel_t                  mll;
  rus_pkg::pixel_t                  mup;
  rus_pkg::pixel_t                  m4;
  rus_pkg::pixel_t                  res_px;
  logic [rus_pkg::OUT_ROW_W-1:0]    res_row;
  logic [rus_pkg::OUT_COL_W-1:0]    res_col;

  always_comb begin
    if (item_q.row_odd && item_q.col_odd) begin
      n_last = 2'd3;
    end else if (item_q.row_odd || item_q.col_odd) begin
      n_last = 2'd1;
    end else begin
      n_last = 2'd0;
    end
  end

  assign last_now = (idx_q == n_last);
  assign out_adv  = !out_v_q || m_axis_tready;
  assign fire     = s1_v_q && out_adv;
  assign ready_o  = !s1_v_q || (fire && last_now);

  assign mll = rus_pkg::avg2(left_i, item_q.px);
  assign mup = rus_pkg::avg2(up_i, item_q.px);
  assign m4  = rus_pkg::avg4(ul_i, up_i, left_i, item_q.px);

  // Result order: upper output row first, then lower columns first.
  always_comb begin
    unique case ({item_q.row_odd, item_q.col_odd, idx_q})
      4'b00_00: begin row_off = 2'd0; col_off = 2'd0; src = SRC_PX;  end
      4'b01_00: begin row_off = 2'd0; col_off = 2'd1; src = SRC_MLL; end
      4'b01_01: begin row_off = 2'd0; col_off = 2'd2; src = SRC_PX;  end
      4'b10_00: begin row_off = 2'd1; col_off = 2'd0; src = SRC_MUP; end
      4'b10_01: begin row_off = 2'd2; col_off = 2'd0; src = SRC_PX;  end
      4'b11_00: begin row_off = 2'd1; col_off = 2'd1; src = SRC_M4;  end
      4'b11_01: begin row_off = 2'd1; col_off = 2'd2; src = SRC_MUP; end
      4'b11_10: begin row_off = 2'd2; col_off = 2'd1; src = SRC_MLL; end
      4'b11_11: begin row_off = 2'd2; col_off = 2'd2; src = SRC_PX;  end
      default:  begin row_off = 2'd0; col_off = 2'd0; src = SRC_PX;  end
    endcase
  end

  always_comb begin
    unique case (src)
      SRC_PX:  res_px = item_q.px;
      SRC_MLL: res_px = mll;
      SRC_MUP: res_px = mup;
      SRC_M4:  res_px = m4;
      default: res_px = item_q.px;
    endcase
  end

  assign res_row = item_q.base_row + rus_pkg::OUT_ROW_W'(row_off);
  assign res_col = item_q.base_col + rus_pkg::OUT_COL_W'(col_off);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      idx_q   <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (load_i) begin
        s1_v_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (fire) begin
        if (last_now) begin
          s1_v_q <= 1'b0;
          idx_q  <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
    if (fire) begin
      out_data_q <= {{rus_pkg::M_PAD_W{1'b0}}, res_px.blue, res_px.green, res_px.red,
                     res_col, res_row};
      out_last_q <= last_now;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `RUS_ASSERT(a_load_only_when_free, load_i |-> ready_o, "pixel loaded while sequencer busy")
  `RUS_ASSERT(a_idx_in_range, s1_v_q |-> idx_q <= n_last, "result index past last result")
  `RUS_ASSERT(a_drain_on_last, (fire && last_now && !load_i) |=> !s1_v_q,
              "sequencer still busy after last result")
  `RUS_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> !s1_v_q && !out_v_q,
                     "sequencer not idle after reset")

endmodule

// ----- rtl/rgb_upscale_three_halves.sv -----
// Top level of the 1.5x RGB scaler: counters, size registers and line store.
`timescale 1ns / 1ps
`include "rgb_upscale_three_halves_assert.svh"
// Timing: the accept edge loads the sequencer and the line store read; the first result
//   word is then registered in the output register once that register is free.
// Rate: a source pixel gives one, two, two or four words through the single result register
//   (even/even, even/odd, odd/even, odd/odd row/column); a new pixel loads as the last word goes.
// Reset: row and column counters clear, both frame sizes go to 512 (or MAX if smaller), the
//   line store is not cleared and needs no clearing pass.
module rgb_upscale_three_halves #(
  parameter int MAX_WIDTH  = rus_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rus_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Size registers: index 0 frame width, index 1 frame height.
  input  logic                                cfg_we_i,
  input  logic [rus_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rus_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Source pixels in raster order.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rus_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // red_in, green_in, blue_in
  // Scaled pixels with coordinates.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rus_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // out_row, out_col, red_out,
                                                             // green_out, blue_out, zero pad
  output logic                                m_axis_tlast   // run_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  localparam logic [CW:0] WLIM_RST = (rus_pkg::FRAME_SIZE_RST > MAX_WIDTH) ?
                                     (CW+1)'(MAX_WIDTH) : (CW+1)'(rus_pkg::FRAME_SIZE_RST);
  localparam logic [RW:0] HLIM_RST = (rus_pkg::FRAME_SIZE_RST > MAX_HEIGHT) ?
                                     (RW+1)'(MAX_HEIGHT) : (RW+1)'(rus_pkg::FRAME_SIZE_RST);

  // Frame sizes are held already clamped to 1..MAX.
  logic [CW:0]                          wlim_q, wlim_d;
  logic [RW:0]                          hlim_q, hlim_d;
  logic [CW-1:0]                        col_q;
  logic [RW-1:0]                        row_q;
  rus_pkg::pixel_t                      left_q;
  rus_pkg::pixel_t                      ul_q;

  logic                                 accept;
  rus_pkg::pixel_t                      px;
  rus_pkg::pixel_t                      up;
  rus_pkg::item_t                       item;
  logic [rus_pkg::FRAME_W_REG_W-1:0]    cfg_w;
  logic [rus_pkg::FRAME_H_REG_W-1:0]    cfg_h;
  logic [CW:0]                          col_inc;
  logic [RW:0]                          row_inc;
  logic [CW+1:0]                        col_half;
  logic [CW+1:0]                        col_tri;
  logic [RW+1:0]                        row_half;
  logic [RW+1:0]                        row_tri;

  assign accept = s_axis_tvalid && s_axis_tready;

  assign px.red   = s_axis_tdata[7:0];
  assign px.green = s_axis_tdata[15:8];
  assign px.blue  = s_axis_tdata[23:16];

  // Clamp a written size (width from the low 12 data bits): zero counts as one, above MAX as MAX.
  assign cfg_w = cfg_data_i[rus_pkg::FRAME_W_REG_W-1:0];
  assign cfg_h = cfg_data_i[rus_pkg::FRAME_H_REG_W-1:0];

  always_comb begin
    priority if (cfg_w == '0) begin
      wlim_d = (CW+1)'(1);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      wlim_d = (CW+1)'(MAX_WIDTH);
    end else begin
      wlim_d = (CW+1)'(cfg_w);
    end
    priority if (cfg_h == '0) begin
      hlim_d = (RW+1)'(1);
    end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
      hlim_d = (RW+1)'(MAX_HEIGHT);
    end else begin
      hlim_d = (RW+1)'(cfg_h);
    end
  end

  // Output block origin: three times the source pair index.
  assign col_half = {2'b0, col_q} >> 1;
  assign col_tri  = col_half + (col_half << 1);
  assign row_half = {2'b0, row_q} >> 1;
  assign row_tri  = row_half + (row_half << 1);

  assign item.row_odd  = row_q[0];
  assign item.col_odd  = col_q[0];
  assign item.base_row = rus_pkg::OUT_ROW_W'(row_tri);
  assign item.base_col = rus_pkg::OUT_COL_W'(col_tri);
  assign item.px       = px;

  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlim_q <= WLIM_RST;
      hlim_q <= HLIM_RST;
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rus_pkg::REG_FRAME_WIDTH:  wlim_q <= wlim_d;
          rus_pkg::REG_FRAME_HEIGHT: hlim_q <= hlim_d;
          default: ;
        endcase
      end
      if (accept) begin
        // Advance the column; wrap it and advance the row at the width, wrapping the row at the height.
        if (col_inc >= wlim_q) begin
          col_q <= '0;
          if (row_inc >= hlim_q) begin
            row_q <= '0;
          end else begin
            row_q <= row_inc[RW-1:0];
          end
        end else begin
          col_q <= col_inc[CW-1:0];
        end
        // Keep the even-column pixel for its odd right neighbor.
        if (!col_q[0]) begin
          left_q <= px;
        end
      end
    end
  end

  // Upper-left neighbor: the previous pixel's line store read, which in an
  // odd row is the entry one column to the left.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ul_q <= up;
    end
  end

  // Even rows write the store, odd rows read the entry above. A write
  // commits at the accept edge, so any later read sees it.
  rus_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && !row_q[0]),
    .waddr_i (col_q),
    .wdata_i (px),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up)
  );

  rus_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .item_i        (item),
    .left_i        (left_q),
    .up_i          (up),
    .ul_i          (ul_q),
    .ready_o       (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `RUS_ASSERT(a_size_clamped,
              wlim_q != '0 && 32'(wlim_q) <= 32'(MAX_WIDTH) && hlim_q != '0 &&
              32'(hlim_q) <= 32'(MAX_HEIGHT), "frame size outside clamp range")
  `RUS_ASSERT(a_col_wraps, (accept && col_inc >= wlim_q) |=> col_q == '0,
              "column did not wrap at frame width")
  `RUS_ASSERT(a_counters_hold, !accept |=> $stable(col_q) && $stable(row_q),
              "position moved without an accepted word")

endmodule
